FILE: rtl/core/ipdse_pkg.sv
// ----------------------------------------------------------------------------
// ipdse_pkg: shared types and constants of the pulse-distance symbol encoder
// holds register indexes, command codes, phase codes and symbol packing
// ----------------------------------------------------------------------------
package ipdse_pkg;

  localparam int MAX_PAYLOAD_BYTES_DEF = 64;

  localparam int TIMING_W = 30;
  localparam int DUR_W    = 15;
  localparam int SYMBOL_W = 32;
  localparam int BYTE_W   = 8;
  localparam int BURST_W  = 8;
  localparam int FRAME_W  = 8;
  localparam int BIT_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic MARK_LEVEL  = 1'b1;
  localparam logic SPACE_LEVEL = 1'b0;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER     = 3'd0,
    REG_ONE        = 3'd1,
    REG_ZERO       = 3'd2,
    REG_INTERFRAME = 3'd3,
    REG_FINAL      = 3'd4,
    REG_BURST      = 3'd5
  } reg_idx_t;

  // input commands
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  // message phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_BITS   = 4'b0010,
    PH_INTER  = 4'b0100,
    PH_FINAL  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TIMING_W-1:0] header_timing;
    logic [TIMING_W-1:0] one_timing;
    logic [TIMING_W-1:0] zero_timing;
    logic [TIMING_W-1:0] interframe_timing;
    logic [TIMING_W-1:0] final_timing;
    logic [BURST_W-1:0]  burst_count;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic sending;
  } seq_status_t;

  // mark in low half with level 1, space in high half with level 0
  function automatic logic [SYMBOL_W-1:0] pack_symbol(input logic [TIMING_W-1:0] timing);
    pack_symbol = {SPACE_LEVEL, timing[2*DUR_W-1:DUR_W], MARK_LEVEL, timing[DUR_W-1:0]};
  endfunction

endpackage

FILE: rtl/core/ipdse_ifs.sv
// ----------------------------------------------------------------------------
// ipdse channel interfaces
// valid/ready channels for items, results and config writes
// ----------------------------------------------------------------------------
interface ipdse_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [ipdse_pkg::BYTE_W-1:0]     payload_byte;
  modport source (output valid, cmd, payload_byte, input ready);
  modport sink   (input valid, cmd, payload_byte, output ready);
endinterface

interface ipdse_out_if;
  logic                             valid;
  logic                             ready;
  logic [ipdse_pkg::SYMBOL_W-1:0]   symbol_word;
  logic                             last_symbol;
  modport source (output valid, symbol_word, last_symbol, input ready);
  modport sink   (input valid, symbol_word, last_symbol, output ready);
endinterface

interface ipdse_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ipdse_pkg::CFG_IDX_W-1:0]  index;
  logic [ipdse_pkg::TIMING_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ipdse_ram.sv
// ----------------------------------------------------------------------------
// ipdse_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ipdse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ipdse_cfg_regs.sv
// ----------------------------------------------------------------------------
// ipdse_cfg_regs: configuration register file
// timing words and burst count, written over the config channel
// ----------------------------------------------------------------------------
module ipdse_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  ipdse_cfg_if.sink         cfg_bus,
  output ipdse_pkg::cfg_t   cfg
);

  ipdse_pkg::cfg_t cfg_r;
  ipdse_pkg::cfg_t cfg_nxt;
  logic            wr;

  assign cfg_bus.ready = 1'b1;
  assign wr = cfg_bus.valid & cfg_bus.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (cfg_bus.index)
        ipdse_pkg::REG_HEADER:     cfg_nxt.header_timing     = cfg_bus.data;
        ipdse_pkg::REG_ONE:        cfg_nxt.one_timing        = cfg_bus.data;
        ipdse_pkg::REG_ZERO:       cfg_nxt.zero_timing       = cfg_bus.data;
        ipdse_pkg::REG_INTERFRAME: cfg_nxt.interframe_timing = cfg_bus.data;
        ipdse_pkg::REG_FINAL:      cfg_nxt.final_timing      = cfg_bus.data;
        ipdse_pkg::REG_BURST:      cfg_nxt.burst_count       =
                                     cfg_bus.data[ipdse_pkg::BURST_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_timing     <= '0;
      cfg_r.one_timing        <= '0;
      cfg_r.zero_timing       <= '0;
      cfg_r.interframe_timing <= '0;
      cfg_r.final_timing      <= '0;
      cfg_r.burst_count       <= ipdse_pkg::BURST_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/ipdse_seq.sv
// ----------------------------------------------------------------------------
// ipdse_seq: message sequencer
// appends payload bytes to the store and walks header, bits, gaps on fetch
// ----------------------------------------------------------------------------
module ipdse_seq #(
  parameter int MAX_PAYLOAD_BYTES = ipdse_pkg::MAX_PAYLOAD_BYTES_DEF,
  localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1,
  localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ipdse_pkg::cfg_t              cfg,
  ipdse_in_if.sink                     in_bus,
  ipdse_out_if.source                  out_bus,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [ipdse_pkg::BYTE_W-1:0] ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  input  logic [ipdse_pkg::BYTE_W-1:0] ram_rdata,
  output ipdse_pkg::seq_status_t       status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } st_t;

  st_t                              state_r, state_nxt;
  ipdse_pkg::phase_t                phase_r, phase_nxt, phase_eff, phase_eof;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [CW-1:0]                    byte_pos_r, byte_pos_nxt, byte_inc;
  logic [ipdse_pkg::BIT_W-1:0]      bit_pos_r, bit_pos_nxt;
  logic [ipdse_pkg::FRAME_W-1:0]    frame_r, frame_nxt;
  logic                             sending_r, sending_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [ipdse_pkg::SYMBOL_W-1:0]   word_r, word_nxt;
  logic                             last_r, last_nxt;
  logic                             acc, is_load, do_emit, payload_bit;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign acc          = in_bus.valid & in_bus.ready;
  assign is_load      = (in_bus.cmd == ipdse_pkg::CMD_LOAD);

  // loads are dropped while sending or when the store is full
  assign ram_we    = acc & is_load & ~sending_r & (count_r < CW'(MAX_PAYLOAD_BYTES));
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = in_bus.payload_byte;
  // byte read issued with the fetch beat, used in the ram-wait state
  assign ram_re    = acc & ~is_load;
  assign ram_raddr = byte_pos_r[AW-1:0];

  assign do_emit     = (state_r == ST_LOOK) & (~out_valid_r | out_bus.ready);
  assign payload_bit = ram_rdata[bit_pos_r];
  assign byte_inc    = byte_pos_r + CW'(1);

  always_comb begin
    phase_eff = phase_r;
    if (phase_r == ipdse_pkg::PH_HEADER && frame_r >= cfg.burst_count) begin
      phase_eff = ipdse_pkg::PH_FINAL;
    end
    if (({1'b0, frame_r} + 9'd1) < {1'b0, cfg.burst_count}) begin
      phase_eof = ipdse_pkg::PH_INTER;
    end else begin
      phase_eof = ipdse_pkg::PH_FINAL;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    byte_pos_nxt  = byte_pos_r;
    bit_pos_nxt   = bit_pos_r;
    frame_nxt     = frame_r;
    sending_nxt   = sending_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & ~out_bus.ready;

    if (ram_we) begin
      count_nxt = count_r + CW'(1);
    end
    if (acc && !is_load) begin
      state_nxt = ST_LOOK;
    end

    if (do_emit) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      sending_nxt   = 1'b1;
      last_nxt      = 1'b0;
      unique case (phase_eff)
        ipdse_pkg::PH_HEADER: begin
          word_nxt     = ipdse_pkg::pack_symbol(cfg.header_timing);
          byte_pos_nxt = '0;
          bit_pos_nxt  = '0;
          phase_nxt    = (count_r != '0) ? ipdse_pkg::PH_BITS : phase_eof;
        end
        ipdse_pkg::PH_BITS: begin
          word_nxt    = ipdse_pkg::pack_symbol(payload_bit ? cfg.one_timing : cfg.zero_timing);
          bit_pos_nxt = bit_pos_r + ipdse_pkg::BIT_W'(1);
          if (bit_pos_r == '1) begin
            byte_pos_nxt = byte_inc;
            if (byte_inc >= count_r) begin
              phase_nxt = phase_eof;
            end
          end
        end
        ipdse_pkg::PH_INTER: begin
          word_nxt     = ipdse_pkg::pack_symbol(cfg.interframe_timing);
          frame_nxt    = frame_r + ipdse_pkg::FRAME_W'(1);
          byte_pos_nxt = '0;
          bit_pos_nxt  = '0;
          phase_nxt    = ipdse_pkg::PH_HEADER;
        end
        ipdse_pkg::PH_FINAL: begin
          word_nxt     = ipdse_pkg::pack_symbol(cfg.final_timing);
          last_nxt     = 1'b1;
          count_nxt    = '0;
          frame_nxt    = '0;
          byte_pos_nxt = '0;
          bit_pos_nxt  = '0;
          phase_nxt    = ipdse_pkg::PH_HEADER;
          sending_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= ipdse_pkg::PH_HEADER;
      count_r     <= '0;
      byte_pos_r  <= '0;
      bit_pos_r   <= '0;
      frame_r     <= '0;
      sending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      byte_pos_r  <= byte_pos_nxt;
      bit_pos_r   <= bit_pos_nxt;
      frame_r     <= frame_nxt;
      sending_r   <= sending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.symbol_word = word_r;
  assign out_bus.last_symbol = last_r;

  assign status.busy    = (state_r == ST_LOOK);
  assign status.sending = sending_r;

endmodule

FILE: rtl/core/ir_pulse_distance_symbol_encoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_symbol_encoder_top: infrared pulse-distance symbol encoder
// loads payload bytes into a ram and hands out one 32-bit symbol per fetch
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                      beat
//  cfg_bus   in    index[2:0], data[29:0]       register write, always ready
//  in_bus    in    cmd, payload_byte[7:0]       load (cmd 0) or fetch (cmd 1)
//  out_bus   out   symbol_word[31:0], last_symbol  one per fetch beat
//
//  a load beat does not hold off in_bus; a fetch beat waits on the
//  registered read of the payload ram (read issued with the fetch beat)
//  in_bus is held off while a fetch waits for its ram data; a result that
//  has not been taken holds the next fetch in its ram-wait state only
//  synchronous active-low reset clears the sequencer and config registers;
//  the payload ram is not cleared, only entries loaded since the last
//  message are ever read
//
module ir_pulse_distance_symbol_encoder_top #(
  parameter int MAX_PAYLOAD_BYTES = ipdse_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ipdse_cfg_if.sink    cfg_bus,
  ipdse_in_if.sink     in_bus,
  ipdse_out_if.source  out_bus
);

  localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

  // register file output; keep it stable while a message is fetched (not enforced)
  ipdse_pkg::cfg_t              cfg;
  ipdse_pkg::seq_status_t       status;

  // payload ram ports
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ipdse_pkg::BYTE_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [ipdse_pkg::BYTE_W-1:0] ram_rdata;

  ipdse_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  // payload store: written at the fill count, read at the current byte
  ipdse_ram #(
    .WIDTH (ipdse_pkg::BYTE_W),
    .DEPTH (MAX_PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: load append, fetch walks header, data bits, gaps, final
  ipdse_seq #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .status    (status)
  );

`ifndef SYNTHESIS
  // a fetch beat always holds off the input while it waits for its ram data
  a_fetch_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.cmd == ipdse_pkg::CMD_FETCH)
    |=> !in_bus.ready)
    else $error("fetch beat did not hold off the input");

  // a load beat never blocks the next beat
  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.cmd == ipdse_pkg::CMD_LOAD)
    |=> in_bus.ready)
    else $error("load beat held off the input");

  // a new result only comes out of the ram-wait cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(status.busy))
    else $error("result appeared without a pending fetch");

  // once the final gap is delivered with no fetch in flight, sending is over
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready && out_bus.last_symbol && !status.busy)
    |=> !status.sending)
    else $error("message still sending after final gap");
`endif

endmodule
